// ----- rtl/sbcc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbcc_pkg: shared types and constants of the segment/box collision checker
// Payload structs, the obstacle entry layout, codes and datapath widths.
// ----------------------------------------------------------------------------
package sbcc_pkg;

    typedef struct packed {
        logic               op;
        logic [5:0]         obstacle_index;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        extent_x;
        logic [30:0]        extent_y;
        logic signed [31:0] from_x;
        logic signed [31:0] from_y;
        logic signed [31:0] to_x;
        logic signed [31:0] to_y;
    } t_in;

    typedef struct packed {
        logic        path_free;
        logic [31:0] segment_length;
        logic        limit_hit;
    } t_out;

    typedef struct packed {
        logic signed [31:0] cen_x;
        logic signed [31:0] cen_y;
        logic [30:0]        ext_x;
        logic [30:0]        ext_y;
    } t_box;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_COUNT = 2'd0;
    localparam logic [1:0] REG_STEP  = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    localparam logic [6:0]  COUNT_RESET = 7'd0;
    localparam logic [15:0] STEP_RESET  = 16'd655;
    localparam logic [19:0] LIMIT_RESET = 20'd65535;

    localparam int FRAC_EXTRA = 24;
    localparam int ROOT_IN_W  = 66;
    localparam int ROOT_W     = 33;
    localparam int DIV_NUM_W  = 72;
    localparam int DIV_DEN_W  = 33;
    localparam int INC_W      = 42;
    localparam int ACC_W      = 58;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAG,
        S_SQX,
        S_SQY,
        S_SUM,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_NDIV_GO,
        S_NDIV_WAIT,
        S_INCX_GO,
        S_INCX_WAIT,
        S_INCY_GO,
        S_INCY_WAIT,
        S_WALK_INIT,
        S_PROBE,
        S_FIN
    } t_state;

endpackage

// ----- rtl/sbcc_obst_ram.sv -----
// ----------------------------------------------------------------------------
// sbcc_obst_ram: obstacle table
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module sbcc_obst_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  sbcc_pkg::t_box i_wdata,
    input  logic [AW-1:0]  i_raddr,
    output sbcc_pkg::t_box o_rdata
);

    sbcc_pkg::t_box r_mem [DEPTH];
    sbcc_pkg::t_box r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sbcc_sqrt.sv -----
// ----------------------------------------------------------------------------
// sbcc_sqrt: iterative integer square root
// Two radicand bits per cycle for a 66-bit radicand.
// ----------------------------------------------------------------------------
module sbcc_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [sbcc_pkg::ROOT_IN_W-1:0]  i_radicand,
    output logic                            o_done,
    output logic [sbcc_pkg::ROOT_W-1:0]     o_root
);

    logic                           r_busy;
    logic                           r_done;
    logic [5:0]                     r_cnt;
    logic [sbcc_pkg::ROOT_IN_W-1:0] r_val;
    logic [35:0]                    r_rem;
    logic [sbcc_pkg::ROOT_W-1:0]    r_root;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        take;

    always_comb begin
        rem_sh = {r_rem[33:0], r_val[sbcc_pkg::ROOT_IN_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        take   = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= 6'd32;
        end else if (r_busy) begin
            r_val <= {r_val[sbcc_pkg::ROOT_IN_W-3:0], 2'b00};
            r_cnt <= r_cnt - 6'd1;
            if (take) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[sbcc_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[sbcc_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- rtl/sbcc_div.sv -----
// ----------------------------------------------------------------------------
// sbcc_div: restoring serial divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbcc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [sbcc_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [sbcc_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                            o_done,
    output logic [sbcc_pkg::DIV_NUM_W-1:0]  o_quot
);

    logic                           r_busy;
    logic                           r_done;
    logic [6:0]                     r_cnt;
    logic [sbcc_pkg::DIV_NUM_W-1:0] r_q;
    logic [sbcc_pkg::DIV_DEN_W-1:0] r_rem;
    logic [sbcc_pkg::DIV_DEN_W-1:0] r_den;

    logic [sbcc_pkg::DIV_DEN_W:0] rem_sh;
    logic [sbcc_pkg::DIV_DEN_W:0] rem_sub;
    logic                         ge;

    always_comb begin
        rem_sh  = {r_rem, r_q[sbcc_pkg::DIV_NUM_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 7'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= 7'(sbcc_pkg::DIV_NUM_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            r_q   <= {r_q[sbcc_pkg::DIV_NUM_W-2:0], ge};
            r_rem <= ge ? rem_sub[sbcc_pkg::DIV_DEN_W-1:0]
                        : rem_sh[sbcc_pkg::DIV_DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- rtl/segment_box_collision_check_unit.sv -----
// ----------------------------------------------------------------------------
// segment_box_collision_check_unit: segment walk against a box obstacle table
// Loads boxes into a table and checks segments by walking sample points.
// ----------------------------------------------------------------------------
//   channel   direction  signals                                   word
//   in        input      i_in_valid, o_in_ready, i_in_data         t_in
//   res       output     o_res_valid, i_res_ready, o_res_data      t_out
//   cfg       input      i_cfg_valid, o_cfg_ready, i_cfg_index/data register write
//
// A load word is written to the table at acceptance.
// A query first sets up: magnitudes, squares and square root, then a serial division
// for the point count and two more for the increments (skipped for a zero-length
// segment). It then reads the table for the N walked points and the endpoint against
// K tested boxes (none when K is 0), one table read per cycle; a hit ends the walk early.
// S_FIN loads the result once the output register is free. Reset is synchronous and
// needs no table clearing; a stalled result stays in the output register until taken.
// ----------------------------------------------------------------------------
module segment_box_collision_check_unit #(
    parameter int MAX_OBSTACLES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sbcc_pkg::t_in  i_in_data,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output sbcc_pkg::t_out o_res_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);

    localparam int AW   = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CW   = $clog2(MAX_OBSTACLES + 1);
    localparam int KW   = (CW > 7) ? CW : 7;
    localparam int ACCX = sbcc_pkg::ACC_W - 32 - sbcc_pkg::FRAC_EXTRA;

    sbcc_pkg::t_state r_state, n_state;

    logic [6:0]  r_cnt_cfg;
    logic [15:0] r_step_cfg;
    logic [19:0] r_limit_cfg;

    logic signed [31:0] r_from_x, r_from_y, r_to_x, r_to_y;
    logic signed [32:0] r_dx, r_dy;
    logic [31:0]        r_mx, r_my;
    logic               r_neg_x, r_neg_y;
    logic [63:0]        r_prod;
    logic [64:0]        r_sum;
    logic [32:0]        r_len;
    logic [19:0]        r_n, r_i;
    logic               r_limited;
    logic signed [sbcc_pkg::INC_W-1:0] r_inc_x, r_inc_y;
    logic signed [sbcc_pkg::ACC_W-1:0] r_acc_x, r_acc_y;
    logic               r_endpt;
    logic [KW-1:0]      r_k;
    logic               r_chk;
    logic               r_blk;
    logic               r_ovld;
    sbcc_pkg::t_out     r_out;

    logic                           in_acc;
    logic                           root_start, root_done;
    logic [sbcc_pkg::ROOT_W-1:0]    root_val;
    logic                           div_start, div_done;
    logic [sbcc_pkg::DIV_NUM_W-1:0] div_num, div_quot;
    logic [sbcc_pkg::DIV_DEN_W-1:0] div_den;
    logic [31:0]                    mul_a, mul_b;
    logic [15:0]                    step_eff;
    logic [KW-1:0]                  cnt_lim, cnt_ext, max_k;
    logic                           ram_we;
    sbcc_pkg::t_box                 ram_wdata, box;
    logic                           issue, inbox, hit, point_done, fin_load;
    logic [sbcc_pkg::ACC_W:0]       dif_x, dif_y;
    logic signed [sbcc_pkg::ACC_W:0] sdif_x, sdif_y, half_x, half_y;
    logic [sbcc_pkg::ACC_W-1:0]     cx, cy, from_ax, from_ay, to_ax, to_ay;
    logic [sbcc_pkg::INC_W-2:0]     inc_mag;
    logic [20:0]                    i_next;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_cfg   <= sbcc_pkg::COUNT_RESET;
            r_step_cfg  <= sbcc_pkg::STEP_RESET;
            r_limit_cfg <= sbcc_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sbcc_pkg::REG_COUNT: r_cnt_cfg   <= i_cfg_data[6:0];
                sbcc_pkg::REG_STEP:  r_step_cfg  <= i_cfg_data[15:0];
                sbcc_pkg::REG_LIMIT: r_limit_cfg <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    assign step_eff = (r_step_cfg == 16'd0) ? 16'd1 : r_step_cfg;
    assign cnt_ext  = KW'(r_cnt_cfg);
    assign max_k    = KW'(MAX_OBSTACLES);
    assign cnt_lim  = (cnt_ext > max_k) ? max_k : cnt_ext;

    // ---------------- obstacle table ----------------
    assign in_acc = i_in_valid && o_in_ready;
    assign ram_we = in_acc && (i_in_data.op == sbcc_pkg::OP_LOAD)
                    && (KW'(i_in_data.obstacle_index) < max_k);

    always_comb begin
        ram_wdata.cen_x = i_in_data.center_x;
        ram_wdata.cen_y = i_in_data.center_y;
        ram_wdata.ext_x = i_in_data.extent_x;
        ram_wdata.ext_y = i_in_data.extent_y;
    end

    sbcc_obst_ram #(
        .DEPTH (MAX_OBSTACLES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_in_data.obstacle_index)),
        .i_wdata (ram_wdata),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (box)
    );

    // ---------------- shared arithmetic units ----------------
    sbcc_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand ({1'b0, r_sum}),
        .o_done     (root_done),
        .o_root     (root_val)
    );

    sbcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // ---------------- point test ----------------
    assign cx      = {{ACCX{box.cen_x[31]}}, box.cen_x, {sbcc_pkg::FRAC_EXTRA{1'b0}}};
    assign cy      = {{ACCX{box.cen_y[31]}}, box.cen_y, {sbcc_pkg::FRAC_EXTRA{1'b0}}};
    assign from_ax = {{ACCX{r_from_x[31]}}, r_from_x, {sbcc_pkg::FRAC_EXTRA{1'b0}}};
    assign from_ay = {{ACCX{r_from_y[31]}}, r_from_y, {sbcc_pkg::FRAC_EXTRA{1'b0}}};
    assign to_ax   = {{ACCX{r_to_x[31]}}, r_to_x, {sbcc_pkg::FRAC_EXTRA{1'b0}}};
    assign to_ay   = {{ACCX{r_to_y[31]}}, r_to_y, {sbcc_pkg::FRAC_EXTRA{1'b0}}};

    always_comb begin
        dif_x  = {cx[sbcc_pkg::ACC_W-1], cx} - {r_acc_x[sbcc_pkg::ACC_W-1], r_acc_x};
        dif_y  = {cy[sbcc_pkg::ACC_W-1], cy} - {r_acc_y[sbcc_pkg::ACC_W-1], r_acc_y};
        sdif_x = $signed(dif_x);
        sdif_y = $signed(dif_y);
        half_x = $signed({5'b0, box.ext_x, 23'b0});
        half_y = $signed({5'b0, box.ext_y, 23'b0});
        inbox  = (sdif_x <= half_x) && (sdif_x >= -half_x)
                 && (sdif_y <= half_y) && (sdif_y >= -half_y);
    end

    assign issue      = r_k < cnt_lim;
    assign hit        = r_chk && inbox;
    assign point_done = !issue && r_chk && !inbox;
    assign i_next     = {1'b0, r_i} + 21'd1;
    assign fin_load   = !r_ovld || i_res_ready;
    assign inc_mag    = div_quot[sbcc_pkg::INC_W-2:0];

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbcc_pkg::S_IDLE: begin
                if (in_acc && i_in_data.op == sbcc_pkg::OP_QUERY) begin
                    n_state = sbcc_pkg::S_MAG;
                end
            end
            sbcc_pkg::S_MAG:     n_state = sbcc_pkg::S_SQX;
            sbcc_pkg::S_SQX:     n_state = sbcc_pkg::S_SQY;
            sbcc_pkg::S_SQY:     n_state = sbcc_pkg::S_SUM;
            sbcc_pkg::S_SUM:     n_state = sbcc_pkg::S_ROOT_GO;
            sbcc_pkg::S_ROOT_GO: n_state = sbcc_pkg::S_ROOT_WAIT;
            sbcc_pkg::S_ROOT_WAIT: begin
                if (root_done) begin
                    n_state = sbcc_pkg::S_NDIV_GO;
                end
            end
            sbcc_pkg::S_NDIV_GO: n_state = sbcc_pkg::S_NDIV_WAIT;
            sbcc_pkg::S_NDIV_WAIT: begin
                if (div_done) begin
                    n_state = (r_len == 33'd0) ? sbcc_pkg::S_WALK_INIT
                                               : sbcc_pkg::S_INCX_GO;
                end
            end
            sbcc_pkg::S_INCX_GO: n_state = sbcc_pkg::S_INCX_WAIT;
            sbcc_pkg::S_INCX_WAIT: begin
                if (div_done) begin
                    n_state = sbcc_pkg::S_INCY_GO;
                end
            end
            sbcc_pkg::S_INCY_GO: n_state = sbcc_pkg::S_INCY_WAIT;
            sbcc_pkg::S_INCY_WAIT: begin
                if (div_done) begin
                    n_state = sbcc_pkg::S_WALK_INIT;
                end
            end
            sbcc_pkg::S_WALK_INIT: begin
                n_state = (cnt_lim == '0) ? sbcc_pkg::S_FIN : sbcc_pkg::S_PROBE;
            end
            sbcc_pkg::S_PROBE: begin
                if (hit || (point_done && r_endpt)) begin
                    n_state = sbcc_pkg::S_FIN;
                end
            end
            sbcc_pkg::S_FIN: begin
                if (fin_load) begin
                    n_state = sbcc_pkg::S_IDLE;
                end
            end
            default: n_state = sbcc_pkg::S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        o_in_ready = 1'b0;
        root_start = 1'b0;
        div_start  = 1'b0;
        div_num    = {{(sbcc_pkg::DIV_NUM_W-48){1'b0}}, r_prod[47:0]} <<
                     sbcc_pkg::FRAC_EXTRA;
        div_den    = r_len;
        mul_a      = r_mx;
        mul_b      = {16'd0, step_eff};
        case (r_state)
            sbcc_pkg::S_IDLE: o_in_ready = 1'b1;
            sbcc_pkg::S_SQX: begin
                mul_b = r_mx;
            end
            sbcc_pkg::S_SQY: begin
                mul_a = r_my;
                mul_b = r_my;
            end
            sbcc_pkg::S_ROOT_GO: root_start = 1'b1;
            sbcc_pkg::S_NDIV_GO: begin
                div_start = 1'b1;
                div_num   = sbcc_pkg::DIV_NUM_W'(r_len);
                div_den   = sbcc_pkg::DIV_DEN_W'(step_eff);
            end
            sbcc_pkg::S_INCX_GO: div_start = 1'b1;
            sbcc_pkg::S_INCX_WAIT: mul_a = r_my;
            sbcc_pkg::S_INCY_GO: begin
                div_start = 1'b1;
                mul_a     = r_my;
            end
            default: ;
        endcase
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            sbcc_pkg::S_IDLE: begin
                r_from_x <= i_in_data.from_x;
                r_from_y <= i_in_data.from_y;
                r_to_x   <= i_in_data.to_x;
                r_to_y   <= i_in_data.to_y;
                r_dx <= {i_in_data.to_x[31], i_in_data.to_x}
                        - {i_in_data.from_x[31], i_in_data.from_x};
                r_dy <= {i_in_data.to_y[31], i_in_data.to_y}
                        - {i_in_data.from_y[31], i_in_data.from_y};
            end
            sbcc_pkg::S_MAG: begin
                r_neg_x <= r_dx[32];
                r_neg_y <= r_dy[32];
                r_mx    <= r_dx[32] ? 32'(-r_dx) : r_dx[31:0];
                r_my    <= r_dy[32] ? 32'(-r_dy) : r_dy[31:0];
            end
            sbcc_pkg::S_SQY: r_sum <= {1'b0, r_prod};
            sbcc_pkg::S_SUM: r_sum <= r_sum + {1'b0, r_prod};
            sbcc_pkg::S_ROOT_WAIT: begin
                if (root_done) begin
                    r_len <= root_val;
                end
            end
            sbcc_pkg::S_NDIV_WAIT: begin
                if (div_done) begin
                    r_inc_x <= '0;
                    r_inc_y <= '0;
                    if (div_quot[32:0] > {13'd0, r_limit_cfg}) begin
                        r_n       <= r_limit_cfg;
                        r_limited <= 1'b1;
                    end else begin
                        r_n       <= div_quot[19:0];
                        r_limited <= 1'b0;
                    end
                end
            end
            sbcc_pkg::S_INCX_WAIT: begin
                if (div_done) begin
                    r_inc_x <= r_neg_x ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
                end
            end
            sbcc_pkg::S_INCY_WAIT: begin
                if (div_done) begin
                    r_inc_y <= r_neg_y ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
                end
            end
            sbcc_pkg::S_WALK_INIT: begin
                r_k     <= '0;
                r_chk   <= 1'b0;
                r_blk   <= 1'b0;
                r_i     <= '0;
                r_endpt <= (r_n == 20'd0);
                if (r_n == 20'd0) begin
                    r_acc_x <= $signed(to_ax);
                    r_acc_y <= $signed(to_ay);
                end else begin
                    r_acc_x <= $signed(from_ax);
                    r_acc_y <= $signed(from_ay);
                end
            end
            sbcc_pkg::S_PROBE: begin
                // A finished point has no read in issue, so the check flag clears here.
                r_chk <= issue;
                if (issue) begin
                    r_k <= r_k + KW'(1);
                end
                if (hit) begin
                    r_blk <= 1'b1;
                end else if (point_done && !r_endpt) begin
                    // Next walked point; the last one is followed by the endpoint.
                    r_k   <= '0;
                    r_i   <= i_next[19:0];
                    if (i_next == {1'b0, r_n}) begin
                        r_endpt <= 1'b1;
                        r_acc_x <= $signed(to_ax);
                        r_acc_y <= $signed(to_ay);
                    end else begin
                        r_acc_x <= r_acc_x + sbcc_pkg::ACC_W'(r_inc_x);
                        r_acc_y <= r_acc_y + sbcc_pkg::ACC_W'(r_inc_y);
                    end
                end
            end
            sbcc_pkg::S_FIN: begin
                if (fin_load) begin
                    r_out.path_free      <= !r_blk;
                    r_out.segment_length <= r_len[32] ? 32'hFFFF_FFFF : r_len[31:0];
                    r_out.limit_hit      <= r_limited;
                end
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbcc_pkg::S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sbcc_pkg::S_FIN && fin_load) begin
                r_ovld <= 1'b1;
            end else if (i_res_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_ovld;
    assign o_res_data  = r_out;

endmodule
